### design/assert_macros.svh
// Assertion macros used by the design checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside of reset.
`define SCQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error(msg);

// Checks that a condition never holds on a rising clock edge outside of reset.
`define SCQ_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    `SCQ_ASSERT(lbl, clk, rst_n, !(expr), msg)

`endif

### design/scq_pkg.sv
// Package with the shared types and constants of the state change qualifier.
`timescale 1ns / 1ps

package scq_pkg;

    localparam int CMD_BITS      = 2;
    localparam int HYST_BITS     = 8;
    localparam int INTERVAL_BITS = 16;
    localparam int DUR_BITS      = 16;
    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 3;

    localparam logic [HYST_BITS-1:0]     REPEAT_MAX       = '1;
    localparam logic [INTERVAL_BITS-1:0] INTERVAL_DEFAULT = INTERVAL_BITS'(1);

    typedef enum logic [CMD_BITS-1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_FORCE  = 2'd1,
        CMD_CLEAR  = 2'd2
    } cmd_t;

    typedef enum logic {
        REG_HYST     = 1'b0,
        REG_INTERVAL = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [HYST_BITS-1:0]     hysteresis_count;
        logic [INTERVAL_BITS-1:0] check_interval;
    } cfg_t;

    typedef struct packed {
        logic action_fire;
        logic check_done;
        logic forced_active;
        logic invalid_request;
    } flags_t;

endpackage

### design/scq_in_if.sv
// Input channel interface: command, time, value and force duration of one beat.
`timescale 1ns / 1ps

interface scq_in_if #(
    parameter int TIME_BITS  = 32,
    parameter int VALUE_BITS = 32
);
    logic                         valid;
    logic                         ready;
    logic [scq_pkg::CMD_BITS-1:0] command;
    logic [TIME_BITS-1:0]         now_ticks;
    logic [VALUE_BITS-1:0]        state_value;
    logic [scq_pkg::DUR_BITS-1:0] force_duration;

    modport source (
        output valid, command, now_ticks, state_value, force_duration,
        input  ready
    );

    modport sink (
        input  valid, command, now_ticks, state_value, force_duration,
        output ready
    );
endinterface

### design/scq_out_if.sv
// Result channel interface: fire flag, states and status bits of one beat.
`timescale 1ns / 1ps

interface scq_out_if #(
    parameter int VALUE_BITS = 32
);
    logic                  valid;
    logic                  ready;
    logic                  action_fire;
    logic [VALUE_BITS-1:0] previous_action_state;
    logic [VALUE_BITS-1:0] effective_state;
    logic                  check_done;
    logic                  forced_active;
    logic                  invalid_request;

    modport source (
        output valid, action_fire, previous_action_state, effective_state,
               check_done, forced_active, invalid_request,
        input  ready
    );

    modport sink (
        input  valid, action_fire, previous_action_state, effective_state,
               check_done, forced_active, invalid_request,
        output ready
    );
endinterface

### design/scq_cfg.sv
// APB register file holding the hysteresis count and the check interval.
`timescale 1ns / 1ps

module scq_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [scq_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  logic [scq_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic [scq_pkg::APB_DATA_BITS-1:0]   prdata,
    output logic                                pready,
    output scq_pkg::cfg_t                       cfg
);
    import scq_pkg::*;

    logic [HYST_BITS-1:0]     hyst_reg;
    logic [INTERVAL_BITS-1:0] interval_reg;
    logic                     wr_en;
    reg_idx_t                 idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = reg_idx_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hyst_reg     <= '0;
            interval_reg <= INTERVAL_DEFAULT;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_HYST:     hyst_reg     <= pwdata[HYST_BITS-1:0];
                REG_INTERVAL: interval_reg <= pwdata[INTERVAL_BITS-1:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_HYST:     prdata = APB_DATA_BITS'(hyst_reg);
            REG_INTERVAL: prdata = APB_DATA_BITS'(interval_reg);
            default:      prdata = '0;
        endcase
    end

    assign cfg.hysteresis_count = hyst_reg;
    assign cfg.check_interval   = interval_reg;
endmodule

### design/scq_eval.sv
// Combinational evaluation of one beat against the current qualifier state.
`timescale 1ns / 1ps

module scq_eval #(
    parameter int TIME_BITS  = 32,
    parameter int VALUE_BITS = 32
) (
    input  scq_pkg::cfg_t                  cfg,
    input  logic [scq_pkg::CMD_BITS-1:0]   command,
    input  logic [TIME_BITS-1:0]           now_ticks,
    input  logic [VALUE_BITS-1:0]          state_value,
    input  logic [scq_pkg::DUR_BITS-1:0]   force_duration,
    input  logic [VALUE_BITS-1:0]          acted,
    input  logic [VALUE_BITS-1:0]          cand,
    input  logic [scq_pkg::HYST_BITS-1:0]  repeat_cnt,
    input  logic [TIME_BITS-1:0]           last_check,
    input  logic                           force_on,
    input  logic [VALUE_BITS-1:0]          force_value,
    input  logic [TIME_BITS-1:0]           force_expiry,
    output logic [VALUE_BITS-1:0]          acted_next,
    output logic [VALUE_BITS-1:0]          cand_next,
    output logic [scq_pkg::HYST_BITS-1:0]  repeat_next,
    output logic [TIME_BITS-1:0]           last_check_next,
    output logic                           force_on_next,
    output logic [VALUE_BITS-1:0]          force_value_next,
    output logic [TIME_BITS-1:0]           force_expiry_next,
    output logic [VALUE_BITS-1:0]          eff_state,
    output scq_pkg::flags_t                flags
);
    import scq_pkg::*;

    logic [TIME_BITS-1:0] deadline;
    logic [TIME_BITS-1:0] due_diff;
    logic [TIME_BITS-1:0] exp_diff;
    logic                 due;
    logic                 force_live;
    logic [HYST_BITS-1:0] repeat_inc;
    logic                 changed;

    // Time comparisons read the wrapped difference as a signed number.
    assign deadline   = last_check + TIME_BITS'(cfg.check_interval);
    assign due_diff   = deadline - now_ticks;
    assign exp_diff   = force_expiry - now_ticks;
    assign due        = due_diff[TIME_BITS-1];
    assign force_live = force_on && !exp_diff[TIME_BITS-1];
    assign repeat_inc = (repeat_cnt == REPEAT_MAX) ? repeat_cnt : repeat_cnt + 1'b1;

    always_comb
    begin
        acted_next        = acted;
        cand_next         = cand;
        repeat_next       = repeat_cnt;
        last_check_next   = last_check;
        force_on_next     = force_on;
        force_value_next  = force_value;
        force_expiry_next = force_expiry;
        eff_state         = '0;
        changed           = 1'b0;
        flags             = '0;

        unique case (command)
            CMD_SAMPLE:
            begin
                if (due)
                begin
                    flags.check_done = 1'b1;
                    force_on_next    = force_live;
                    last_check_next  = now_ticks;
                    if (force_live)
                    begin
                        eff_state = force_value;
                        changed   = (acted != force_value);
                    end
                    else
                    begin
                        eff_state = state_value;
                        if (cfg.hysteresis_count == '0)
                        begin
                            changed = (acted != state_value);
                        end
                        else if (acted == state_value)
                        begin
                            repeat_next = '0;
                            cand_next   = state_value;
                        end
                        else if (cand == state_value)
                        begin
                            if (repeat_inc >= cfg.hysteresis_count)
                            begin
                                repeat_next = '0;
                                changed     = 1'b1;
                            end
                            else
                            begin
                                repeat_next = repeat_inc;
                            end
                        end
                        else
                        begin
                            cand_next   = state_value;
                            repeat_next = HYST_BITS'(1);
                        end
                    end
                    if (changed)
                    begin
                        acted_next = eff_state;
                    end
                end
            end
            CMD_FORCE:
            begin
                if (force_duration == '0)
                begin
                    flags.invalid_request = 1'b1;
                end
                else
                begin
                    force_value_next  = state_value;
                    force_expiry_next = now_ticks + TIME_BITS'(force_duration);
                    force_on_next     = 1'b1;
                end
            end
            CMD_CLEAR:
            begin
                force_on_next = 1'b0;
            end
            default:
            begin
            end
        endcase

        flags.action_fire   = changed;
        flags.forced_active = force_on_next;
    end
endmodule

### design/state_change_qualifier_with_force.sv
// Top level of the state change qualifier with timed force override.
`timescale 1ns / 1ps

// The block takes one beat per clock unless the result register stalls it, and
// returns exactly one result beat for each. An accepted beat lands in an input
// register, is evaluated combinationally against the qualifier state, and its result
// is written into the result register once that register is empty or being taken;
// the state it leaves is used by the very next beat. The input ready stays high while
// the result register is empty or being taken, so with a ready sink the sustained rate
// is one beat per cycle. Registers are written over APB at byte address 0 (hysteresis
// count) and 4 (check interval); write them only while no beat is in flight.
module state_change_qualifier_with_force #(
    parameter int TIME_BITS  = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    scq_in_if.sink                            item,
    scq_out_if.source                         result,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [scq_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [scq_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [scq_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                              pready
);
    import scq_pkg::*;

    cfg_t cfg;

    logic                  s1_valid_reg;
    logic [CMD_BITS-1:0]   cmd_reg;
    logic [TIME_BITS-1:0]  now_reg;
    logic [VALUE_BITS-1:0] value_reg;
    logic [DUR_BITS-1:0]   dur_reg;

    logic [VALUE_BITS-1:0] acted_reg, acted_next;
    logic [VALUE_BITS-1:0] cand_reg, cand_next;
    logic [HYST_BITS-1:0]  repeat_reg, repeat_next;
    logic [TIME_BITS-1:0]  last_check_reg, last_check_next;
    logic                  force_on_reg, force_on_next;
    logic [VALUE_BITS-1:0] force_value_reg, force_value_next;
    logic [TIME_BITS-1:0]  force_expiry_reg, force_expiry_next;

    logic [VALUE_BITS-1:0] eff_state;
    flags_t                flags;

    logic                  out_valid_reg;
    flags_t                out_flags_reg;
    logic [VALUE_BITS-1:0] out_prev_reg;
    logic [VALUE_BITS-1:0] out_eff_reg;

    logic s1_adv;
    logic in_take;

    scq_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    scq_eval #(
        .TIME_BITS  (TIME_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_eval (
        .cfg               (cfg),
        .command           (cmd_reg),
        .now_ticks         (now_reg),
        .state_value       (value_reg),
        .force_duration    (dur_reg),
        .acted             (acted_reg),
        .cand              (cand_reg),
        .repeat_cnt        (repeat_reg),
        .last_check        (last_check_reg),
        .force_on          (force_on_reg),
        .force_value       (force_value_reg),
        .force_expiry      (force_expiry_reg),
        .acted_next        (acted_next),
        .cand_next         (cand_next),
        .repeat_next       (repeat_next),
        .last_check_next   (last_check_next),
        .force_on_next     (force_on_next),
        .force_value_next  (force_value_next),
        .force_expiry_next (force_expiry_next),
        .eff_state         (eff_state),
        .flags             (flags)
    );

    assign s1_adv     = s1_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !s1_valid_reg || s1_adv;
    assign in_take    = item.valid && item.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            s1_valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            cmd_reg   <= item.command;
            now_reg   <= item.now_ticks;
            value_reg <= item.state_value;
            dur_reg   <= item.force_duration;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acted_reg        <= '0;
            cand_reg         <= '0;
            repeat_reg       <= '0;
            last_check_reg   <= '0;
            force_on_reg     <= 1'b0;
            force_value_reg  <= '0;
            force_expiry_reg <= '0;
        end
        else if (s1_adv)
        begin
            acted_reg        <= acted_next;
            cand_reg         <= cand_next;
            repeat_reg       <= repeat_next;
            last_check_reg   <= last_check_next;
            force_on_reg     <= force_on_next;
            force_value_reg  <= force_value_next;
            force_expiry_reg <= force_expiry_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_flags_reg <= flags;
            out_prev_reg  <= acted_reg;
            out_eff_reg   <= eff_state;
        end
    end

    assign result.valid                 = out_valid_reg;
    assign result.action_fire           = out_flags_reg.action_fire;
    assign result.previous_action_state = out_prev_reg;
    assign result.effective_state       = out_eff_reg;
    assign result.check_done            = out_flags_reg.check_done;
    assign result.forced_active         = out_flags_reg.forced_active;
    assign result.invalid_request       = out_flags_reg.invalid_request;
endmodule

### design/scq_checker.sv
// Port-level checker for the state change qualifier and its bind statement.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module scq_props #(
    parameter int VALUE_BITS = 32
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic                  action_fire,
    input logic [VALUE_BITS-1:0] previous_action_state,
    input logic [VALUE_BITS-1:0] effective_state,
    input logic                  check_done,
    input logic                  invalid_request
);
    // A held result beat keeps its effective state and fire flag.
    `SCQ_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(effective_state) && $stable(action_fire), "result beat changed while stalled")

    // A firing beat was evaluated and moved the acted state to a new value.
    `SCQ_ASSERT(a_fire_change, clk, rst_n, out_valid && action_fire |-> check_done && (effective_state != previous_action_state), "fire without a real change")

    // A rejected force never evaluates or fires.
    `SCQ_ASSERT_NEVER(a_inval_quiet, clk, rst_n, out_valid && invalid_request && (check_done || action_fire), "invalid force reported a check")

    // A result appears once the beat that caused it has passed the input register and the result register.
    `SCQ_ASSERT(a_latency, clk, rst_n, $rose(out_valid) |-> $past(in_valid && in_ready, 2), "result without an accepted beat")
endmodule

bind state_change_qualifier_with_force scq_props #(
    .VALUE_BITS (VALUE_BITS)
) u_scq_props (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (item.valid),
    .in_ready              (item.ready),
    .out_valid             (result.valid),
    .out_ready             (result.ready),
    .action_fire           (result.action_fire),
    .previous_action_state (result.previous_action_state),
    .effective_state       (result.effective_state),
    .check_done            (result.check_done),
    .invalid_request       (result.invalid_request)
);

### bench/scq_checker.sv
// Checker that predicts every result beat of the state change qualifier and compares it.
`timescale 1ns / 1ps

module scq_checker #(
    parameter int TIME_BITS  = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    scq_in_if                                 in_ch,
    scq_out_if                                out_ch,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [scq_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [scq_pkg::APB_DATA_BITS-1:0] pwdata,
    input  logic                              pready,
    output int unsigned                       fail_count,
    output int unsigned                       results_checked,
    output int unsigned                       fires_seen,
    output int unsigned                       outstanding
);
    import scq_pkg::*;

    localparam logic [APB_ADDR_BITS-1:0] HYST_ADDR     = {REG_HYST, 2'b00};
    localparam logic [APB_ADDR_BITS-1:0] INTERVAL_ADDR = {REG_INTERVAL, 2'b00};

    typedef struct packed {
        logic                  action_fire;
        logic [VALUE_BITS-1:0] previous_action_state;
        logic [VALUE_BITS-1:0] effective_state;
        logic                  check_done;
        logic                  forced_active;
        logic                  invalid_request;
    } outcome_t;

    cfg_t                  cfg;
    logic [VALUE_BITS-1:0] last_fired_value;
    logic [VALUE_BITS-1:0] pending_value;
    logic [HYST_BITS-1:0]  match_run;
    logic [TIME_BITS-1:0]  last_eval_tick;
    logic                  override_on;
    logic [VALUE_BITS-1:0] override_value;
    logic [TIME_BITS-1:0]  override_end;
    outcome_t              due_outcomes[$];

    function automatic logic is_after(logic [TIME_BITS-1:0] a, logic [TIME_BITS-1:0] b);
        logic [TIME_BITS-1:0] diff;
        diff = b - a;
        return diff[TIME_BITS-1];
    endfunction

    function automatic outcome_t step_qualifier(logic [CMD_BITS-1:0] cmd,
                                                logic [TIME_BITS-1:0] now,
                                                logic [VALUE_BITS-1:0] val,
                                                logic [DUR_BITS-1:0] dur);
        outcome_t r;
        logic     changed;
        r = '0;
        changed = 1'b0;
        r.previous_action_state = last_fired_value;
        case (cmd)
            CMD_SAMPLE:
            begin
                if (is_after(now, last_eval_tick + TIME_BITS'(cfg.check_interval)))
                begin
                    r.check_done = 1'b1;
                    if (override_on && is_after(now, override_end))
                    begin
                        override_on = 1'b0;
                    end
                    if (override_on)
                    begin
                        r.effective_state = override_value;
                        changed = (last_fired_value != override_value);
                    end
                    else
                    begin
                        r.effective_state = val;
                        if (cfg.hysteresis_count == '0)
                        begin
                            changed = (last_fired_value != val);
                        end
                        else if (last_fired_value == val)
                        begin
                            match_run = '0;
                            pending_value = val;
                        end
                        else if (pending_value == val)
                        begin
                            if (match_run != REPEAT_MAX)
                            begin
                                match_run = match_run + 1'b1;
                            end
                            if (match_run >= cfg.hysteresis_count)
                            begin
                                match_run = '0;
                                changed = 1'b1;
                            end
                        end
                        else
                        begin
                            pending_value = val;
                            match_run = HYST_BITS'(1);
                        end
                    end
                    if (changed)
                    begin
                        r.action_fire = 1'b1;
                        last_fired_value = r.effective_state;
                    end
                    last_eval_tick = now;
                end
            end
            CMD_FORCE:
            begin
                if (dur == '0)
                begin
                    r.invalid_request = 1'b1;
                end
                else
                begin
                    override_value = val;
                    override_end = now + TIME_BITS'(dur);
                    override_on = 1'b1;
                end
            end
            CMD_CLEAR:
            begin
                override_on = 1'b0;
            end
            default:
            begin
            end
        endcase
        r.forced_active = override_on;
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got, inout int unsigned errs);
        if (want !== got)
        begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            errs++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t    got;
        outcome_t    want;
        int unsigned errs;
        if (!rst_n)
        begin
            cfg.hysteresis_count = '0;
            cfg.check_interval = INTERVAL_DEFAULT;
            last_fired_value = '0;
            pending_value = '0;
            match_run = '0;
            last_eval_tick = '0;
            override_on = 1'b0;
            override_value = '0;
            override_end = '0;
            due_outcomes.delete();
            fail_count <= 0;
            results_checked <= 0;
            fires_seen <= 0;
            outstanding <= 0;
        end
        else
        begin
            errs = 0;
            if (out_ch.valid && out_ch.ready)
            begin
                got.action_fire = out_ch.action_fire;
                got.previous_action_state = out_ch.previous_action_state;
                got.effective_state = out_ch.effective_state;
                got.check_done = out_ch.check_done;
                got.forced_active = out_ch.forced_active;
                got.invalid_request = out_ch.invalid_request;
                if (due_outcomes.size() == 0)
                begin
                    $error("Result beat arrived while no result was expected.");
                    errs++;
                end
                else
                begin
                    want = due_outcomes.pop_front();
                    compare_field("action_fire", want.action_fire, got.action_fire, errs);
                    compare_field("previous_action_state", want.previous_action_state,
                                  got.previous_action_state, errs);
                    compare_field("effective_state", want.effective_state,
                                  got.effective_state, errs);
                    compare_field("check_done", want.check_done, got.check_done, errs);
                    compare_field("forced_active", want.forced_active, got.forced_active,
                                  errs);
                    compare_field("invalid_request", want.invalid_request,
                                  got.invalid_request, errs);
                end
                results_checked <= results_checked + 1;
                if (got.action_fire === 1'b1)
                begin
                    fires_seen <= fires_seen + 1;
                end
            end
            if (psel && penable && pwrite && pready)
            begin
                case (paddr)
                    HYST_ADDR:     cfg.hysteresis_count = pwdata[HYST_BITS-1:0];
                    INTERVAL_ADDR: cfg.check_interval = pwdata[INTERVAL_BITS-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (in_ch.valid && in_ch.ready)
            begin
                due_outcomes.push_back(step_qualifier(in_ch.command, in_ch.now_ticks,
                                                      in_ch.state_value,
                                                      in_ch.force_duration));
            end
            fail_count <= fail_count + errs;
            outstanding <= due_outcomes.size();
        end
    end

endmodule

### bench/tb_state_change_qualifier_with_force.sv
// Top of the bench for the state change qualifier: stimulus, register writes and verdict.
`timescale 1ns / 1ps

module tb_state_change_qualifier_with_force;
    import scq_pkg::*;

    localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;
    localparam int                  CLK_PERIOD = 20;
    localparam int                  RUN_LIMIT  = 10_000_000;

    logic                     clk;
    logic                     rst_n;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [APB_ADDR_BITS-1:0] paddr;
    logic [APB_DATA_BITS-1:0] pwdata;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;

    int unsigned fail_count;
    int unsigned results_checked;
    int unsigned fires_seen;
    int unsigned outstanding;
    int unsigned beats_sent;
    int unsigned settings_run;
    int unsigned cur_interval;
    int unsigned pool_size;
    bit          steady;
    logic [31:0] tick;
    logic [31:0] value_pool[4];

    scq_in_if  item_ch ();
    scq_out_if result_ch ();

    state_change_qualifier_with_force i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item_ch),
        .result  (result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    scq_checker i_qual_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_ch           (item_ch),
        .out_ch          (result_ch),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .fail_count      (fail_count),
        .results_checked (results_checked),
        .fires_seen      (fires_seen),
        .outstanding     (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial
    begin
        #(RUN_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic int unsigned random_gap();
        int unsigned r;
        if (steady)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 98)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 40);
    endfunction

    initial
    begin
        int unsigned stall;
        result_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            result_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            stall = random_gap();
            if (stall != 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    task automatic send_beat(logic [CMD_BITS-1:0] cmd, logic [31:0] now, logic [31:0] val,
                             logic [DUR_BITS-1:0] dur);
        int unsigned gap;
        gap = random_gap();
        if (gap != 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.command <= cmd;
        item_ch.now_ticks <= now;
        item_ch.state_value <= val;
        item_ch.force_duration <= dur;
        do @(posedge clk); while (!item_ch.ready);
        beats_sent++;
    endtask

    // Holds the sender off until every result is back, then lets the pipeline settle.
    task automatic settle();
        item_ch.valid <= 1'b0;
        while (results_checked < beats_sent) @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
    endtask

    function automatic logic [31:0] pick_value(int unsigned noise_pct);
        if ($urandom_range(0, 99) < noise_pct / 2)
        begin
            return $urandom;
        end
        return value_pool[$urandom_range(0, pool_size - 1)];
    endfunction

    function automatic logic [31:0] next_now(int unsigned noise_pct);
        int unsigned r;
        if ($urandom_range(0, 99) >= noise_pct)
        begin
            tick = tick + 32'(cur_interval + 1 + $urandom_range(0, 2));
            return tick;
        end
        r = $urandom_range(0, 99);
        if (r < 50)
        begin
            tick = tick + 32'($urandom_range(0, cur_interval));
            return tick;
        end
        if (r < 80)
        begin
            return tick - 32'($urandom_range(1, 3 * cur_interval));
        end
        tick = tick + 32'($urandom_range(cur_interval + 1, 32'h4000_0000));
        return tick;
    endfunction

    task automatic run_phase(int unsigned hyst, int unsigned interval, int unsigned count,
                             int unsigned pool_n, int unsigned force_pct,
                             int unsigned noise_pct, bit no_idle, bit fresh_pool);
        int unsigned         r;
        logic [CMD_BITS-1:0] cmd;
        logic [DUR_BITS-1:0] dur;
        logic [31:0]         now;
        settle();
        write_reg(REG_HYST, hyst);
        write_reg(REG_INTERVAL, interval);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        cur_interval = interval;
        steady = no_idle;
        settings_run++;
        if (fresh_pool)
        begin
            pool_size = pool_n;
            foreach (value_pool[i])
            begin
                value_pool[i] = $urandom;
            end
        end
        repeat (count)
        begin
            r = $urandom_range(0, 99);
            dur = DUR_BITS'($urandom_range(0, 16'hFFFF));
            if (r < force_pct)
            begin
                cmd = CMD_FORCE;
                r = $urandom_range(0, 99);
                if (r < 10)
                begin
                    dur = '0;
                end
                else if (r < 15)
                begin
                    dur = '1;
                end
                else
                begin
                    dur = DUR_BITS'($urandom_range(1, (cur_interval * 6 > 65535) ?
                                                       65535 : cur_interval * 6));
                end
            end
            else if (noise_pct != 0 && r < force_pct + 4)
            begin
                cmd = CMD_CLEAR;
            end
            else if (noise_pct != 0 && r < force_pct + 5)
            begin
                cmd = CMD_UNUSED;
            end
            else
            begin
                cmd = CMD_SAMPLE;
            end
            now = next_now(noise_pct);
            send_beat(cmd, now, pick_value(noise_pct), dur);
            if ($urandom_range(0, 199) == 0)
            begin
                settle();
            end
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        item_ch.valid <= 1'b0;
        item_ch.command <= CMD_SAMPLE;
        item_ch.now_ticks <= '0;
        item_ch.state_value <= '0;
        item_ch.force_duration <= '0;
        beats_sent = 0;
        settings_run = 0;
        cur_interval = 1;
        pool_size = 1;
        steady = 1'b0;
        tick = '0;
        foreach (value_pool[i])
        begin
            value_pool[i] = '0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: immediate firing, one tick interval.
        send_beat(CMD_SAMPLE, 32'd0, 32'd5, '0);
        send_beat(CMD_SAMPLE, 32'd1, 32'd5, '0);
        send_beat(CMD_SAMPLE, 32'd2, 32'hFFFF_FFFF, '1);
        send_beat(CMD_SAMPLE, 32'd4, 32'hFFFF_FFFF, '0);
        send_beat(CMD_SAMPLE, 32'd6, 32'd0, '0);
        send_beat(CMD_FORCE, 32'd7, 32'hA5A5_A5A5, '0);
        send_beat(CMD_FORCE, 32'd8, 32'h1234_5678, 16'd10);
        send_beat(CMD_SAMPLE, 32'd10, 32'd0, '0);
        send_beat(CMD_SAMPLE, 32'd18, 32'd0, '0);
        send_beat(CMD_SAMPLE, 32'd20, 32'd3, '0);
        send_beat(CMD_FORCE, 32'd21, 32'hDEAD_BEEF, '1);
        send_beat(CMD_CLEAR, 32'd22, 32'd0, '0);
        send_beat(CMD_SAMPLE, 32'd24, 32'd3, '0);
        send_beat(CMD_UNUSED, 32'd25, 32'hFFFF_FFFF, '1);
        send_beat(CMD_SAMPLE, 32'hFFFF_FFF0, 32'd7, '0);
        send_beat(CMD_SAMPLE, 32'h7FFF_FFFF, 32'h8000_0000, '0);
        send_beat(CMD_SAMPLE, 32'hFFFF_FFFE, 32'd1, '0);
        send_beat(CMD_SAMPLE, 32'd2, 32'd1, '0);
        send_beat(CMD_FORCE, 32'd3, 32'hFFFF_FFFF, 16'd1);
        send_beat(CMD_SAMPLE, 32'd5, 32'd1, '0);
        send_beat(CMD_FORCE, 32'hFFFF_FFF0, 32'd0, '1);
        send_beat(CMD_SAMPLE, 32'hFFFF_FFF8, 32'd9, '0);
        send_beat(CMD_SAMPLE, 32'd7, 32'd9, '0);
        tick = 32'hFFFF_0000;

        run_phase(0, 1, 120, 3, 10, 25, 1'b0, 1'b1);
        run_phase(1, 1, 100, 3, 8, 10, 1'b1, 1'b1);
        run_phase(3, 7, 150, 2, 10, 20, 1'b0, 1'b1);
        run_phase(255, 65535, 260, 1, 0, 0, 1'b0, 1'b1);
        // A run left short of a high count must fire once the count is lowered under it.
        run_phase(200, 2, 150, 1, 0, 0, 1'b0, 1'b1);
        run_phase(100, 2, 40, 1, 0, 0, 1'b0, 1'b0);
        run_phase($urandom_range(2, 6), $urandom_range(1, 300), 150, 4, 12, 25, 1'b0, 1'b1);
        run_phase(0, 65535, 60, 2, 10, 20, 1'b0, 1'b1);

        settle();
        repeat (4) @(posedge clk);
        $display("Summary: %0d beats sent, a directed opening plus %0d register settings.",
                 beats_sent, settings_run);
        $display("Summary: %0d result beats checked, %0d of them fired the action.",
                 results_checked, fires_seen);
        if (fail_count == 0 && outstanding == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
